[sv/icsum_pkg.sv]
// shared widths, types and helpers for the streaming internet checksum
// no dependencies
package icsum_pkg;

  localparam int BYTE_W = 8;
  localparam int CSUM_W = 16;
  localparam int SUM_W = CSUM_W + 2;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [CSUM_W-1:0] UDP_PROTO = CSUM_W'(17);
  localparam logic [CSUM_W-1:0] UDP_HDR_LEN = CSUM_W'(8);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CSUM_W-1:0] csum_t;
  typedef logic [SUM_W-1:0] wide_sum_t;

  typedef struct packed {
    byte_t data_byte;
    logic last_byte;
  } icsum_step_t;

  // end-around fold of a sum of up to four 16-bit terms
  function automatic csum_t oc_fold(input wide_sum_t s);
    logic [CSUM_W:0] f1;
    logic [CSUM_W:0] f2;
    f1 = {1'b0, s[CSUM_W-1:0]} + (CSUM_W+1)'(s[SUM_W-1:CSUM_W]);
    f2 = {1'b0, f1[CSUM_W-1:0]} + (CSUM_W+1)'(f1[CSUM_W]);
    return f2[CSUM_W-1:0];
  endfunction

endpackage

[sv/icsum_if.sv]
// valid/ready channel interfaces for packet bytes and checksum results
// depends on icsum_pkg
interface byte_stream_if;
  import icsum_pkg::*;
  logic valid;
  logic ready;
  byte_t data_byte;
  logic last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csum_if;
  import icsum_pkg::*;
  logic valid;
  logic ready;
  csum_t checksum;
  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

[sv/icsum_accum.sv]
// per-packet ones'-complement accumulator, byte pairing and saturating byte count
// depends on icsum_pkg
module icsum_accum #(
  parameter int COUNT_WIDTH = icsum_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  udp_mode,
  input  logic                  step_en,
  input  icsum_pkg::icsum_step_t step,
  output icsum_pkg::csum_t      checksum
);
  import icsum_pkg::*;

  csum_t acc;
  csum_t acc_next;
  byte_t held;
  byte_t held_next;
  logic pending;
  logic pending_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [31:0] count_ext;
  csum_t len_term;
  csum_t word;
  logic add_udp;
  wide_sum_t total;
  csum_t folded;

  always_comb begin
    count_inc = (count == '1) ? count : count + COUNT_WIDTH'(1);
    count_ext = 32'(count_inc);
    len_term = count_ext[CSUM_W-1:0] - UDP_HDR_LEN;
    word = pending ? {held, step.data_byte} : {step.data_byte, BYTE_W'(0)};
    add_udp = step.last_byte && udp_mode;
    total = SUM_W'(acc) + SUM_W'(word)
          + (add_udp ? SUM_W'(UDP_PROTO) : '0)
          + (add_udp ? SUM_W'(len_term) : '0);
    folded = oc_fold(total);
    checksum = ~folded;
  end

  always_comb begin
    acc_next = acc;
    held_next = held;
    pending_next = pending;
    count_next = count;
    if (step_en) begin
      if (step.last_byte) begin
        acc_next = '0;
        held_next = '0;
        pending_next = 1'b0;
        count_next = '0;
      end else if (pending) begin
        acc_next = folded;
        held_next = '0;
        pending_next = 1'b0;
        count_next = count_inc;
      end else begin
        held_next = step.data_byte;
        pending_next = 1'b1;
        count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      held <= '0;
      pending <= 1'b0;
      count <= '0;
    end else begin
      acc <= acc_next;
      held <= held_next;
      pending <= pending_next;
      count <= count_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step_en && step.last_byte |=> acc == '0 && !pending && count == '0)
    else $error("packet state not cleared after last byte");

  a_pending_toggles: assert property (@(posedge clk) disable iff (rst)
    step_en && !step.last_byte |=> pending != $past(pending))
    else $error("byte pairing out of step");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    step_en && !step.last_byte && count == '1 |=> count == '1)
    else $error("byte count wrapped");

endmodule

[sv/internet_checksum_stream_core.sv]
// streaming internet checksum: one byte per transfer, checksum on the last byte
// the last byte is taken into the input register, then its checksum is captured in the result register
// throughput: one byte per cycle, back-pressure only when a finished checksum is held
// reset: synchronous rst clears udp_mode, packet state and both pipeline stages
// depends on icsum_pkg, icsum_if, icsum_accum
module internet_checksum_stream_core #(
  parameter int COUNT_WIDTH = icsum_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  byte_stream_if.sink   byte_in,
  csum_if.source        csum_out
);
  import icsum_pkg::*;

  logic udp_mode;
  logic s1_valid;
  icsum_step_t s1_step;
  logic advance;
  logic out_valid;
  logic out_valid_next;
  csum_t out_csum;
  csum_t step_csum;

  assign advance = s1_valid && (!s1_step.last_byte || !out_valid || csum_out.ready);
  assign byte_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      udp_mode <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_step <= '{data_byte: byte_in.data_byte, last_byte: byte_in.last_byte};
    end
  end

  icsum_accum #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .udp_mode (udp_mode),
    .step_en  (advance),
    .step     (s1_step),
    .checksum (step_csum)
  );

  // result register
  always_comb begin
    out_valid_next = out_valid;
    if (advance && s1_step.last_byte) begin
      out_valid_next = 1'b1;
    end else if (csum_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_step.last_byte) begin
      out_csum <= step_csum;
    end
  end

  assign csum_out.valid = out_valid;
  assign csum_out.checksum = out_csum;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> byte_in.ready)
    else $error("input stalled with empty stage");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_step.last_byte))
    else $error("result without a last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !csum_out.ready |=> out_valid && $stable(out_csum))
    else $error("held checksum overwritten");

endmodule

[tb/checksum_checker.sv]
// checksum checker: watches the byte and checksum channels and the udp_mode write port,
// predicts each packet's checksum and compares it with what the block returns
// depends on icsum_pkg and icsum_if
module checksum_checker (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_wr_en,
  input  logic   cfg_wr_data,
  byte_stream_if byte_mon,
  csum_if        csum_mon,
  output int     fail_count,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import icsum_pkg::*;

  localparam int COUNT_W = COUNT_WIDTH_DEF;

  logic               udp_on;
  csum_t              run_sum;
  byte_t              high_hold;
  logic               have_high;
  logic [COUNT_W-1:0] pkt_len;
  csum_t              expected_sums[$];
  int                 errors = 0;

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic csum_t ones_add(input csum_t a, input csum_t b);
    logic [CSUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CSUM_W-1:0] + CSUM_W'(s[CSUM_W]);
  endfunction

  always @(posedge clk) begin
    csum_t word;
    csum_t want;
    if (rst) begin
      udp_on = 1'b0;
      run_sum = '0;
      high_hold = '0;
      have_high = 1'b0;
      pkt_len = '0;
      expected_sums.delete();
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        if (pkt_len != '1) pkt_len = pkt_len + 1'b1;
        if (!byte_mon.last_byte) begin
          if (have_high) begin
            run_sum = ones_add(run_sum, {high_hold, byte_mon.data_byte});
            have_high = 1'b0;
            high_hold = '0;
          end else begin
            high_hold = byte_mon.data_byte;
            have_high = 1'b1;
          end
        end else begin
          word = have_high ? {high_hold, byte_mon.data_byte} : {byte_mon.data_byte, 8'h00};
          run_sum = ones_add(run_sum, word);
          if (udp_on) begin
            run_sum = ones_add(run_sum, UDP_PROTO);
            run_sum = ones_add(run_sum, CSUM_W'(pkt_len - COUNT_W'(UDP_HDR_LEN)));
          end
          expected_sums.push_back(~run_sum);
          run_sum = '0;
          high_hold = '0;
          have_high = 1'b0;
          pkt_len = '0;
        end
      end
      if (csum_mon.valid && csum_mon.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: checksum transfer with none expected, actual %h",
                   $time, csum_mon.checksum);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (csum_mon.checksum !== want) begin
            $display("%0t: checksum mismatch, expected %h actual %h",
                     $time, want, csum_mon.checksum);
            errors++;
          end
        end
      end
      if (cfg_wr_en) udp_on = cfg_wr_data;
    end
    outstanding <= expected_sums.size();
    fail_count <= errors;
  end

endmodule

[tb/testbench.sv]
// top of the internet_checksum_stream_core regression: clock, reset, packet stimulus,
// udp_mode writes and output back-pressure; checking lives in checksum_checker
// depends on icsum_pkg, icsum_if, checksum_checker and the core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import icsum_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  bit   source_gaps = 1'b1;
  bit   sink_gaps = 1'b1;
  bit   hold_req = 1'b0;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;

  byte_stream_if byte_in ();
  csum_if        csum_out ();

  internet_checksum_stream_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_in     (byte_in),
    .csum_out    (csum_out)
  );

  checksum_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_mon    (byte_in),
    .csum_mon    (csum_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("internet_checksum_stream_core regression: fail");
      $finish;
    end
  end

  // checksum sink with random stalls and one long hold-off
  initial begin
    csum_out.ready = 1'b0;
    forever begin
      if (hold_req) begin
        csum_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        csum_out.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        csum_out.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic byte_t pick_byte(input bit corner);
    if (!corner) return byte_t'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  task automatic send_byte(input byte_t value, input logic is_last);
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= value;
    byte_in.last_byte <= is_last;
    do @(posedge clk); while (byte_in.ready !== 1'b1);
  endtask

  task automatic source_gap();
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      byte_in.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_seq(input byte_t vals[$], input logic close);
    for (int i = 0; i < vals.size(); i++) begin
      send_byte(vals[i], close && (i == vals.size() - 1));
      source_gap();
    end
  endtask

  task automatic send_packet(input int len, input bit corner, input logic close);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(corner), close && (i == len - 1));
      source_gap();
    end
  endtask

  // all checksums back and the pipeline empty
  task automatic drain();
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_udp(input logic mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int n_bytes, input bit allow_gaps);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      source_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
      sink_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 24);
      send_packet(len, $urandom_range(0, 4) == 0, 1'b1);
      sent += len;
    end
    // leave a packet, possibly empty, open across the next udp_mode write
    send_packet($urandom_range(0, 5), 1'b0, 1'b0);
  endtask

  initial begin
    byte_t seq[$];
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.last_byte = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sum, all-ones sums, end-around carry, odd length
    seq = {8'h00};
    send_seq(seq, 1'b1);
    seq = {8'hFF, 8'hFF};
    send_seq(seq, 1'b1);
    seq = {8'h7F, 8'hFF, 8'h80, 8'h00};
    send_seq(seq, 1'b1);
    seq = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_seq(seq, 1'b1);
    seq = {8'h80, 8'h00, 8'h80, 8'h00, 8'h12};
    send_seq(seq, 1'b1);

    // udp: short length wraps, exact header length
    drain();
    write_udp(1'b1);
    seq = {8'h00};
    send_seq(seq, 1'b1);
    seq = {8'hC0, 8'hA8, 8'h00, 8'h01, 8'hC0, 8'hA8, 8'h00, 8'h02};
    send_seq(seq, 1'b1);

    // mode change in the middle of a packet
    seq = {8'hAB, 8'hCD, 8'hEF};
    send_seq(seq, 1'b0);
    drain();
    write_udp(1'b0);
    seq = {8'h01};
    send_seq(seq, 1'b1);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_udp(p[0]);
      run_phase(60, 1'b1);
    end

    // long sink hold-off while short packets keep coming
    drain();
    write_udp(1'b1);
    source_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_packet($urandom_range(1, 3), 1'b0, 1'b1);

    // final stretch without idling
    drain();
    write_udp(1'b0);
    run_phase(40, 1'b0);
    seq = {8'h5A};
    send_seq(seq, 1'b1);
    drain();

    if (fail_count == 0) begin
      $display("internet_checksum_stream_core regression: pass");
    end else begin
      $display("internet_checksum_stream_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/icsum_pkg.sv
sv/icsum_if.sv
sv/icsum_accum.sv
sv/internet_checksum_stream_core.sv
tb/checksum_checker.sv
tb/testbench.sv
